/* hdl/rcr_pkg.sv */
// ============================================================================
// rcr_pkg: shared definitions for the rectangle canvas rasterizer
// Field widths, command and register codes, default sizes and the span
// test result that passes between the sequencer and the coverage unit.
// ============================================================================
package rcr_pkg;

    // Fixed field widths of the stream items and configuration registers.
    localparam int POS_W    = 19;   // signed corner coordinate
    localparam int END_W    = 20;   // corner plus size, signed
    localparam int SIZE_W   = 18;   // unsigned rectangle size
    localparam int CHAR_W   = 8;
    localparam int RD_W     = 8;    // read row and read column
    localparam int CMD_W    = 2;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 2;

    // Default build sizes.
    localparam int DEFAULT_MAX_COLS  = 256;
    localparam int DEFAULT_MAX_ROWS  = 256;
    localparam int DEFAULT_FRAC_BITS = 8;

    // Command codes carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0]  RESET_CANVAS_WIDTH  = 9'd256;
    localparam logic [CFG_W-1:0]  RESET_CANVAS_HEIGHT = 9'd256;
    localparam logic [CHAR_W-1:0] RESET_BACKGROUND    = 8'd32;

    // Coverage of one coordinate by a span.
    typedef struct packed {
        logic in_range;   // start <= coord and coord < trunc(end)
        logic on_edge;    // coord is trunc(start) or trunc(end) - 1
    } span_t;

endpackage

/* hdl/rcr_span.sv */
// ============================================================================
// rcr_span: span coverage unit
// Tests one integer coordinate against a fixed-point span given by its
// start and its end (start plus size), for both filled and outline rules.
// ============================================================================
module rcr_span #(
    parameter int PW        = 8,
    parameter int FRAC_BITS = rcr_pkg::DEFAULT_FRAC_BITS
) (
    input  logic [PW-1:0]                    coord,
    input  logic signed [rcr_pkg::POS_W-1:0] span_start,
    input  logic signed [rcr_pkg::END_W-1:0] span_end,
    output rcr_pkg::span_t                   result
);

    localparam int CW = (PW + FRAC_BITS + 3 > rcr_pkg::END_W + 2) ?
                        PW + FRAC_BITS + 3 : rcr_pkg::END_W + 2;

    logic signed [CW-1:0] step;
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] hi2;
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] e;
    logic                 start_edge;
    logic                 end_edge;

    // c < trunc(end) is the same as (c + 1) * 2^F <= end for c >= 0,
    // which holds for negative ends as well, so no truncation is needed.
    always_comb
    begin
        step = $signed(CW'(1)) <<< FRAC_BITS;
        lo   = $signed({{(CW-PW){1'b0}}, coord}) <<< FRAC_BITS;
        hi   = lo + step;
        hi2  = hi + step;
        s    = {{(CW-rcr_pkg::POS_W){span_start[rcr_pkg::POS_W-1]}}, span_start};
        e    = {{(CW-rcr_pkg::END_W){span_end[rcr_pkg::END_W-1]}}, span_end};

        // A start just below zero truncates to column zero.
        start_edge = ((lo <= s) && (s < hi)) ||
                     ((coord == '0) && (s < 0) && ((s + step) > 0));
        end_edge   = (hi <= e) && (e < hi2);

        result.in_range = (lo >= s) && (hi <= e);
        result.on_edge  = start_edge || end_edge;
    end

endmodule

/* hdl/rectangle_canvas_rasterizer.sv */
// ============================================================================
// rectangle_canvas_rasterizer: character canvas with rectangle fill/outline
// Holds a canvas in on-chip memory, clears it, paints rectangles into it
// and reads single pixels back, one command at a time.
// ============================================================================
// Usage. Commands arrive on the slave stream: tuser holds the command and
// the outline flag, tdata holds the rectangle, the paint character and the
// read position. Every accepted command gives exactly one result transaction
// on the master stream: the pixel in tdata and the status flag in tuser.
// The user sets canvas size and background via the write port while idle;
// the block does not enforce this.
// Clear and draw sweep the canvas in use row by row through one shared span
// test unit: each row has its row test (ST_ROW), then one column per cycle
// (ST_COL). A read goes through ST_READ on the one memory read port, and a
// rejected draw or read, an unused command or an empty canvas go straight
// to ST_DONE. The block takes one command at a time and is not ready while
// it works.
//
// Reset clears the control state and loads the register defaults (256 by
// 256 canvas, space as background); the canvas memory holds no defined
// value until a clear or a draw writes it. When the receiver stalls, the
// result waits in the output register and the next command is still taken;
// its own result waits in the sequencer until the output register is free.
// ============================================================================
module rectangle_canvas_rasterizer #(
    parameter int MAX_COLS  = rcr_pkg::DEFAULT_MAX_COLS,
    parameter int MAX_ROWS  = rcr_pkg::DEFAULT_MAX_ROWS,
    parameter int FRAC_BITS = rcr_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [rcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcr_pkg::CFG_W-1:0]      cfg_data,
    // Command stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata from bit 0 up: rect_x[18:0], rect_y[18:0], rect_width[17:0],
    // rect_height[17:0], paint_char[7:0], read_row[7:0], read_col[7:0],
    // then six zero bits.
    input  logic [103:0]                   s_tdata,
    // tuser from bit 0 up: command[1:0], outline.
    input  logic [2:0]                     s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: pixel[7:0].
    output logic [7:0]                     m_tdata,
    // tuser: status.
    output logic [0:0]                     m_tuser
);

    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int PW    = (CIW > RIW) ? CIW : RIW;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PRW   = AW + 10;
    localparam logic [10:0] MAXC = 11'(MAX_COLS);
    localparam logic [10:0] MAXR = 11'(MAX_ROWS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_COL,
        ST_READ,
        ST_DONE
    } state_t;

    // Input fields.
    logic [rcr_pkg::CMD_W-1:0]         command;
    logic                              outline;
    logic signed [rcr_pkg::POS_W-1:0]  rect_x;
    logic signed [rcr_pkg::POS_W-1:0]  rect_y;
    logic [rcr_pkg::SIZE_W-1:0]        rect_width;
    logic [rcr_pkg::SIZE_W-1:0]        rect_height;
    logic [rcr_pkg::CHAR_W-1:0]        paint_char;
    logic [rcr_pkg::RD_W-1:0]          read_row;
    logic [rcr_pkg::RD_W-1:0]          read_col;

    assign command     = s_tuser[1:0];
    assign outline     = s_tuser[2];
    assign rect_x      = s_tdata[18:0];
    assign rect_y      = s_tdata[37:19];
    assign rect_width  = s_tdata[55:38];
    assign rect_height = s_tdata[73:56];
    assign paint_char  = s_tdata[81:74];
    assign read_row    = s_tdata[89:82];
    assign read_col    = s_tdata[97:90];

    // Configuration registers.
    logic [rcr_pkg::CFG_W-1:0]  canvas_width_reg;
    logic [rcr_pkg::CFG_W-1:0]  canvas_height_reg;
    logic [rcr_pkg::CHAR_W-1:0] background_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= rcr_pkg::RESET_CANVAS_WIDTH;
            canvas_height_reg <= rcr_pkg::RESET_CANVAS_HEIGHT;
            background_reg    <= rcr_pkg::RESET_BACKGROUND;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcr_pkg::CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data;
                rcr_pkg::CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data;
                rcr_pkg::CFG_BACKGROUND:    background_reg    <= cfg_data[7:0];
                default:                    ;
            endcase
        end
    end

    // Canvas size in use, limited to the memory size.
    logic [10:0] eff_cols;
    logic [10:0] eff_rows;
    logic        canvas_empty;
    logic        read_outside;
    logic [PRW-1:0] read_prod;

    always_comb
    begin
        eff_cols = ({2'b00, canvas_width_reg} > MAXC) ? MAXC : {2'b00, canvas_width_reg};
        eff_rows = ({2'b00, canvas_height_reg} > MAXR) ? MAXR : {2'b00, canvas_height_reg};
        canvas_empty = (eff_cols == 11'd0) || (eff_rows == 11'd0);
        read_outside = ({3'b000, read_row} >= eff_rows) || ({3'b000, read_col} >= eff_cols);
        read_prod = PRW'(read_row) * PRW'(MAX_COLS) + PRW'(read_col);
    end

    // Sequencer state.
    state_t                           state_reg, state_next;
    logic                             clear_reg, clear_next;
    logic                             outline_reg, outline_next;
    logic [rcr_pkg::CHAR_W-1:0]       char_reg, char_next;
    logic signed [rcr_pkg::POS_W-1:0] sx_reg, sx_next;
    logic signed [rcr_pkg::END_W-1:0] ex_reg, ex_next;
    logic signed [rcr_pkg::POS_W-1:0] sy_reg, sy_next;
    logic signed [rcr_pkg::END_W-1:0] ey_reg, ey_next;
    logic [CIW-1:0]                   col_reg, col_next;
    logic [RIW-1:0]                   row_reg, row_next;
    logic [CIW-1:0]                   last_col_reg, last_col_next;
    logic [RIW-1:0]                   last_row_reg, last_row_next;
    logic [AW-1:0]                    row_base_reg, row_base_next;
    logic [AW-1:0]                    rd_addr_reg, rd_addr_next;
    logic                             row_in_reg, row_in_next;
    logic                             row_edge_reg, row_edge_next;
    logic [rcr_pkg::CHAR_W-1:0]       res_pixel_reg, res_pixel_next;
    logic                             res_status_reg, res_status_next;
    logic                             res_mem_reg, res_mem_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [7:0]                       m_tdata_reg, m_tdata_next;
    logic                             m_tuser_reg, m_tuser_next;

    // Shared span test: the row coordinate in the row cycle, else the column.
    logic [PW-1:0]                    span_coord;
    logic signed [rcr_pkg::POS_W-1:0] span_start;
    logic signed [rcr_pkg::END_W-1:0] span_end;
    rcr_pkg::span_t                   span;
    logic                             hit;
    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic [rcr_pkg::CHAR_W-1:0]       mem_q;

    always_comb
    begin
        if (state_reg == ST_ROW)
        begin
            span_coord = PW'(row_reg);
            span_start = sy_reg;
            span_end   = ey_reg;
        end
        else
        begin
            span_coord = PW'(col_reg);
            span_start = sx_reg;
            span_end   = ex_reg;
        end
    end

    rcr_span #(
        .PW        (PW),
        .FRAC_BITS (FRAC_BITS)
    ) u_span (
        .coord      (span_coord),
        .span_start (span_start),
        .span_end   (span_end),
        .result     (span)
    );

    always_comb
    begin
        if (clear_reg)
            hit = 1'b1;
        else if (outline_reg)
            hit = (span.on_edge && row_in_reg) || (row_edge_reg && span.in_range);
        else
            hit = span.in_range && row_in_reg;
        mem_we    = (state_reg == ST_COL) && hit;
        mem_waddr = row_base_reg + AW'(col_reg);
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        clear_next      = clear_reg;
        outline_next    = outline_reg;
        char_next       = char_reg;
        sx_next         = sx_reg;
        ex_next         = ex_reg;
        sy_next         = sy_reg;
        ey_next         = ey_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        last_col_next   = last_col_reg;
        last_row_next   = last_row_reg;
        row_base_next   = row_base_reg;
        rd_addr_next    = rd_addr_reg;
        row_in_next     = row_in_reg;
        row_edge_next   = row_edge_reg;
        res_pixel_next  = res_pixel_reg;
        res_status_next = res_status_reg;
        res_mem_next    = res_mem_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_pixel_next  = '0;
                    res_status_next = 1'b0;
                    res_mem_next    = 1'b0;
                    clear_next      = (command == rcr_pkg::CMD_CLEAR);
                    outline_next    = outline;
                    char_next       = (command == rcr_pkg::CMD_CLEAR) ?
                                      background_reg : paint_char;
                    sx_next         = rect_x;
                    sy_next         = rect_y;
                    ex_next         = $signed({rect_x[rcr_pkg::POS_W-1], rect_x}) +
                                      $signed({2'b00, rect_width});
                    ey_next         = $signed({rect_y[rcr_pkg::POS_W-1], rect_y}) +
                                      $signed({2'b00, rect_height});
                    col_next        = '0;
                    row_next        = '0;
                    row_base_next   = '0;
                    last_col_next   = CIW'(eff_cols - 11'd1);
                    last_row_next   = RIW'(eff_rows - 11'd1);
                    rd_addr_next    = AW'(read_prod);
                    state_next      = ST_DONE;
                    case (command)
                        rcr_pkg::CMD_CLEAR:
                        begin
                            if (!canvas_empty)
                                state_next = ST_ROW;
                        end
                        rcr_pkg::CMD_DRAW:
                        begin
                            if ((rect_width == '0) || (rect_height == '0))
                                res_status_next = 1'b1;
                            else if (!canvas_empty)
                                state_next = ST_ROW;
                        end
                        rcr_pkg::CMD_READ:
                        begin
                            if (read_outside)
                                res_status_next = 1'b1;
                            else
                                state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROW:
            begin
                row_in_next   = span.in_range;
                row_edge_next = span.on_edge;
                state_next    = ST_COL;
            end
            ST_COL:
            begin
                if (col_reg == last_col_reg)
                begin
                    col_next = '0;
                    if (row_reg == last_row_reg)
                        state_next = ST_DONE;
                    else
                    begin
                        row_next      = row_reg + 1'b1;
                        row_base_next = row_base_reg + AW'(MAX_COLS);
                        state_next    = ST_ROW;
                    end
                end
                else
                    col_next = col_reg + 1'b1;
            end
            ST_READ:
            begin
                res_mem_next = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_mem_reg ? mem_q : res_pixel_reg;
                    m_tuser_next  = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clear_reg      <= 1'b0;
            outline_reg    <= 1'b0;
            char_reg       <= '0;
            sx_reg         <= '0;
            ex_reg         <= '0;
            sy_reg         <= '0;
            ey_reg         <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            last_col_reg   <= '0;
            last_row_reg   <= '0;
            row_base_reg   <= '0;
            rd_addr_reg    <= '0;
            row_in_reg     <= 1'b0;
            row_edge_reg   <= 1'b0;
            res_pixel_reg  <= '0;
            res_status_reg <= 1'b0;
            res_mem_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_reg      <= clear_next;
            outline_reg    <= outline_next;
            char_reg       <= char_next;
            sx_reg         <= sx_next;
            ex_reg         <= ex_next;
            sy_reg         <= sy_next;
            ey_reg         <= ey_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            last_col_reg   <= last_col_next;
            last_row_reg   <= last_row_next;
            row_base_reg   <= row_base_next;
            rd_addr_reg    <= rd_addr_next;
            row_in_reg     <= row_in_next;
            row_edge_reg   <= row_edge_next;
            res_pixel_reg  <= res_pixel_next;
            res_status_reg <= res_status_next;
            res_mem_reg    <= res_mem_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            m_tuser_reg    <= m_tuser_next;
        end
    end

    // Canvas memory: one write port for the sweep, one registered read port.
    logic [rcr_pkg::CHAR_W-1:0] canvas_mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            canvas_mem[mem_waddr] <= char_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            mem_q <= canvas_mem[rd_addr_reg];
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

/* hdl/rcr_checker.sv */
// ============================================================================
// rcr_checker: port-level checks for the rectangle canvas rasterizer
// Watches the stream ports over time and is bound to the top level.
// ============================================================================
module rcr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser
);

    // A stalled result holds its value.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One command at a time: no second transaction right after one is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while busy");

    // A new result comes out of the busy phase, never straight from idle.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a command in flight");

    // A rejected command never carries a pixel.
    a_reject_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
        else $error("nonzero pixel on rejected command");

endmodule

bind rectangle_canvas_rasterizer rcr_checker u_rcr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* verif/rcr_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// rcr_scoreboard: result predictor and scoreboard for the canvas rasterizer
// Watches the register port and both streams, keeps its own copy of the
// canvas and registers, and compares every result with the oldest prediction.
// ============================================================================
module rcr_scoreboard (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcr_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [103:0]                   s_tdata,
    input  logic [2:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [7:0]                     m_tdata,
    input  logic [0:0]                     m_tuser,
    output int                             outstanding,
    output int                             mismatches
);

    localparam int COLS_MAX = rcr_pkg::DEFAULT_MAX_COLS;
    localparam int ROWS_MAX = rcr_pkg::DEFAULT_MAX_ROWS;
    localparam int FRAC     = rcr_pkg::DEFAULT_FRAC_BITS;

    typedef struct {
        logic [7:0] pixel;
        logic       status;
    } pixel_result_t;

    pixel_result_t expected_q[$];
    logic [7:0]    canvas_chars [0:ROWS_MAX*COLS_MAX-1];
    logic [rcr_pkg::CFG_W-1:0]  width_reg;
    logic [rcr_pkg::CFG_W-1:0]  height_reg;
    logic [rcr_pkg::CHAR_W-1:0] bg_reg;

    function automatic longint trunc_frac(longint v);
        if (v >= 0)
            return v >>> FRAC;
        return -((-v) >>> FRAC);
    endfunction

    function automatic int used_cols();
        return (width_reg > COLS_MAX) ? COLS_MAX : int'(width_reg);
    endfunction

    function automatic int used_rows();
        return (height_reg > ROWS_MAX) ? ROWS_MAX : int'(height_reg);
    endfunction

    task automatic paint_rect(logic hollow, longint x, longint y, longint w, longint h,
                              logic [7:0] ch);
        longint xs, ys, xe, ye;
        bit     in_x, in_y, hit;
        xs = trunc_frac(x);
        ys = trunc_frac(y);
        xe = trunc_frac(x + w);
        ye = trunc_frac(y + h);
        for (int r = 0; r < used_rows(); r++) begin
            in_y = ((longint'(r) <<< FRAC) >= y) && (r < ye);
            for (int c = 0; c < used_cols(); c++) begin
                in_x = ((longint'(c) <<< FRAC) >= x) && (c < xe);
                if (!hollow)
                    hit = in_x && in_y;
                else
                    hit = ((c == xs || c == xe - 1) && in_y) ||
                          ((r == ys || r == ye - 1) && in_x);
                if (hit)
                    canvas_chars[r*COLS_MAX + c] = ch;
            end
        end
    endtask

    task automatic apply_command(logic [rcr_pkg::CMD_W-1:0] cmd, logic hollow,
                                 logic [103:0] d);
        pixel_result_t res;
        int            row, col;
        res.pixel  = '0;
        res.status = 1'b0;
        case (cmd)
            rcr_pkg::CMD_CLEAR:
            begin
                for (int r = 0; r < used_rows(); r++)
                    for (int c = 0; c < used_cols(); c++)
                        canvas_chars[r*COLS_MAX + c] = bg_reg;
            end
            rcr_pkg::CMD_DRAW:
            begin
                // A zero width or height is rejected and paints nothing.
                if (d[55:38] == '0 || d[73:56] == '0)
                    res.status = 1'b1;
                else
                    paint_rect(hollow, longint'($signed(d[18:0])),
                               longint'($signed(d[37:19])),
                               longint'(d[55:38]), longint'(d[73:56]), d[81:74]);
            end
            rcr_pkg::CMD_READ:
            begin
                row = int'(d[89:82]);
                col = int'(d[97:90]);
                if (row >= used_rows() || col >= used_cols())
                    res.status = 1'b1;
                else
                    res.pixel = canvas_chars[row*COLS_MAX + col];
            end
            default:
            begin
                // The unused code changes nothing and reports success.
            end
        endcase
        expected_q.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t exp_res;
        if (!rst_n)
        begin
            expected_q.delete();
            width_reg   = rcr_pkg::RESET_CANVAS_WIDTH;
            height_reg  = rcr_pkg::RESET_CANVAS_HEIGHT;
            bg_reg      = rcr_pkg::RESET_BACKGROUND;
            outstanding = 0;
            mismatches  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rcr_pkg::CFG_CANVAS_WIDTH:  width_reg  = cfg_data;
                    rcr_pkg::CFG_CANVAS_HEIGHT: height_reg = cfg_data;
                    rcr_pkg::CFG_BACKGROUND:    bg_reg     = cfg_data[rcr_pkg::CHAR_W-1:0];
                    default:
                    begin
                        // Writes beyond the register list are dropped.
                    end
                endcase
            end
            // Results are retired before new commands are predicted: a result
            // can never belong to a command accepted at the same edge.
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result pixel %h status %0d with nothing outstanding",
                                 $realtime, m_tdata, m_tuser[0]);
                    mismatches++;
                end
                else
                begin
                    exp_res = expected_q.pop_front();
                    if (m_tdata !== exp_res.pixel || m_tuser[0] !== exp_res.status)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch pixel exp %h got %h, status exp %0d got %0d",
                                     $realtime, exp_res.pixel, m_tdata, exp_res.status,
                                     m_tuser[0]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_command(s_tuser[1:0], s_tuser[2], s_tdata);
            outstanding = expected_q.size();
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top: stimulus and verdict for the rectangle canvas rasterizer
// Runs a directed pass over the field extremes and special cases, then
// random phases on small canvases, with random idling on both streams.
// ============================================================================
module tb_top;

    // Codes the package does not name: the spare command and register index.
    localparam logic [rcr_pkg::CMD_W-1:0]     CMD_UNUSED   = 2'd3;
    localparam logic [rcr_pkg::CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;
    localparam int                            RANDOM_ITEMS = 76;
    // A full 256 by 256 sweep shows no transaction at all, so the watchdog
    // limit is set well above the length of such a sweep.
    localparam int                            STALL_LIMIT  = 300000;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [rcr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rcr_pkg::CFG_W-1:0]      cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    // tdata from bit 0 up: rect_x[18:0], rect_y[18:0], rect_width[17:0],
    // rect_height[17:0], paint_char[7:0], read_row[7:0], read_col[7:0], zeros.
    logic [103:0]                   s_tdata;
    // tuser from bit 0 up: command[1:0], outline.
    logic [2:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    // tdata: pixel[7:0].
    logic [7:0]                     m_tdata;
    // tuser: status.
    logic [0:0]                     m_tuser;

    int outstanding;
    int mismatches;
    // While calm is set neither side idles.
    bit calm;
    // Canvas size in use, after clamping, so reads can aim inside it.
    int cur_cols;
    int cur_rows;

    rectangle_canvas_rasterizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    rcr_scoreboard u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver stalls at random, with a chance of 36 in a hundred, except when calm.
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 36);

    // The watchdog ends the run as failed once its quiet counter, cleared by any
    // transaction on either stream or by reset, reaches STALL_LIMIT.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Presents one command and returns at the edge where it is accepted. The
    // valid is left high, so a following call can keep the stream busy.
    task automatic send_cmd(logic [rcr_pkg::CMD_W-1:0] cmd, logic hollow, int x, int y,
                            int w, int h, int ch, int row, int col);
        while (!calm && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, col[7:0], row[7:0], ch[7:0], h[17:0], w[17:0], y[18:0], x[18:0]};
        s_tuser  <= {hollow, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_read(int row, int col);
        send_cmd(rcr_pkg::CMD_READ, 1'b0, 0, 0, 0, 0, 0, row, col);
    endtask

    // Lowers the valid and waits until every result has come back. The first
    // edge lets the checker record a command accepted at the current edge.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [rcr_pkg::CFG_IDX_W-1:0] idx, int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[rcr_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_canvas(int cols, int rows, int bg);
        write_reg(rcr_pkg::CFG_CANVAS_WIDTH, cols);
        write_reg(rcr_pkg::CFG_CANVAS_HEIGHT, rows);
        write_reg(rcr_pkg::CFG_BACKGROUND, bg);
        cur_cols = (cols > rcr_pkg::DEFAULT_MAX_COLS) ? rcr_pkg::DEFAULT_MAX_COLS : cols;
        cur_rows = (rows > rcr_pkg::DEFAULT_MAX_ROWS) ? rcr_pkg::DEFAULT_MAX_ROWS : rows;
    endtask

    initial
    begin
        int phase;
        int random_items;
        int n_items;
        int pick;
        int x, y, w, h;
        int row, col;
        int cols, rows;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        calm      = 1'b0;
        cur_cols  = int'(rcr_pkg::RESET_CANVAS_WIDTH);
        cur_rows  = int'(rcr_pkg::RESET_CANVAS_HEIGHT);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset sizes: the full 256 by 256 canvas. Every
        // read comes after a clear, since unwritten pixels are undefined.
        send_cmd(rcr_pkg::CMD_CLEAR, 1'b0, 0, 0, 0, 0, 0, 0, 0);
        send_read(255, 255);
        // Outline with a fractional left edge and a negative fractional top:
        // the column trunc(x) is painted although it lies left of the corner,
        // and the top row truncates toward zero.
        send_cmd(rcr_pkg::CMD_DRAW, 1'b1, 32'h180, -32'sh80, 32'h3FFFF, 32'h500, 8'h52, 0, 0);
        send_read(0, 1);
        send_read(0, 0);
        send_read(3, 200);
        send_read(2, 100);
        // Zero width and zero height are rejected.
        send_cmd(rcr_pkg::CMD_DRAW, 1'b0, 0, 0, 0, 32'h100, 8'hFF, 0, 0);
        send_cmd(rcr_pkg::CMD_DRAW, 1'b1, 0, 0, 32'h100, 0, 8'hFF, 0, 0);
        send_cmd(CMD_UNUSED, 1'b1, -1, -1, -1, -1, 8'hFF, 8'hFF, 8'hFF);
        wait_idle();

        // A width above the maximum is clamped; two rows keep the sweep short.
        // Bit 8 of the background write is dropped.
        set_canvas(511, 2, 9'h1FF);
        send_cmd(rcr_pkg::CMD_CLEAR, 1'b0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(rcr_pkg::CMD_DRAW, 1'b0, 32'h3FFFF, -32'sh40000, 32'h3FFFF, 32'h3FFFF,
                 8'h00, 0, 0);
        send_cmd(rcr_pkg::CMD_DRAW, 1'b0, -32'sh40000, -32'sh40000, 32'h3FFFF, 32'h3FFFF,
                 8'h01, 0, 0);
        send_cmd(rcr_pkg::CMD_DRAW, 1'b0, -32'sh80, 0, 32'h200, 32'h100, 8'h72, 0, 0);
        send_read(0, 0);
        send_read(1, 255);
        send_read(2, 0);
        wait_idle();

        // An empty canvas, with a write to the index past the register list.
        write_reg(CFG_UNUSED, 9'h0AA);
        set_canvas(0, 5, 8'h41);
        send_cmd(rcr_pkg::CMD_CLEAR, 1'b0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(rcr_pkg::CMD_DRAW, 1'b0, 0, 0, 32'h400, 32'h400, 8'h42, 0, 0);
        send_read(0, 0);
        wait_idle();

        // A single pixel canvas with a zero background.
        set_canvas(1, 1, 0);
        send_cmd(rcr_pkg::CMD_CLEAR, 1'b0, 0, 0, 0, 0, 0, 0, 0);
        send_read(0, 0);
        send_read(0, 1);
        send_read(1, 0);
        wait_idle();

        // Random phases. Each one picks a canvas, clears it, and then runs a
        // mix of well-formed rectangles around the canvas, reads, and noise.
        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            phase++;
            calm = (phase == 3 || phase == 4);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                cols = $urandom_range(256, 511);
                rows = $urandom_range(1, 3);
            end
            else if (pick == 1)
            begin
                cols = $urandom_range(1, 3);
                rows = $urandom_range(256, 511);
            end
            else if (pick == 2)
            begin
                cols = $urandom_range(0, 8);
                rows = 0;
            end
            else
            begin
                cols = $urandom_range(1, 20);
                rows = $urandom_range(1, 16);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, $urandom_range(0, 511));
            set_canvas(cols, rows, $urandom_range(0, 511));
            send_cmd(rcr_pkg::CMD_CLEAR, 1'($urandom_range(0, 1)), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            random_items++;

            n_items = $urandom_range(6, 14);
            repeat (n_items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    // A rectangle near the canvas: it may straddle it, cover it or miss it.
                    x = int'($urandom_range(0, (cur_cols + 6) * 256)) - 3 * 256;
                    y = int'($urandom_range(0, (cur_rows + 6) * 256)) - 3 * 256;
                    w = $urandom_range(1, (cur_cols + 4) * 256);
                    h = $urandom_range(1, (cur_rows + 4) * 256);
                    // Whole-pixel corners and sizes hit the edges exactly.
                    if ($urandom_range(0, 2) == 0)
                    begin
                        x = x & ~32'hFF;
                        y = y & ~32'hFF;
                    end
                    if ($urandom_range(0, 2) == 0)
                    begin
                        w = (w | 32'hFF) + 1;
                        h = (h | 32'hFF) + 1;
                    end
                    send_cmd(rcr_pkg::CMD_DRAW, 1'($urandom_range(0, 1)), x, y, w, h,
                             $urandom(), 0, 0);
                end
                else if (pick < 75)
                begin
                    if (cur_rows > 0 && cur_cols > 0 && $urandom_range(0, 3) != 0)
                    begin
                        row = $urandom_range(0, cur_rows - 1);
                        col = $urandom_range(0, cur_cols - 1);
                    end
                    else
                    begin
                        row = $urandom_range(0, 255);
                        col = $urandom_range(0, 255);
                    end
                    send_read(row, col);
                end
                else if (pick < 85)
                    send_cmd(rcr_pkg::CMD_DRAW, 1'($urandom_range(0, 1)), $urandom(),
                             $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom());
                else if (pick < 90)
                    send_cmd(rcr_pkg::CMD_DRAW, 1'($urandom_range(0, 1)), $urandom(),
                             $urandom(),
                             ($urandom_range(0, 1) == 0) ? 0 : $urandom(),
                             ($urandom_range(0, 1) == 0) ? 0 : $urandom(),
                             $urandom(), 0, 0);
                else if (pick < 95)
                    send_cmd(rcr_pkg::CMD_CLEAR, 1'($urandom_range(0, 1)), 0, 0, 0, 0, 0,
                             0, 0);
                else
                    send_cmd(CMD_UNUSED, 1'($urandom_range(0, 1)), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                random_items++;
            end
            wait_idle();
        end
        calm = 1'b0;

        // All results are in; a short extra wait catches any stray output.
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* rectangle_canvas_rasterizer.f */
hdl/rcr_pkg.sv
hdl/rcr_span.sv
hdl/rectangle_canvas_rasterizer.sv
hdl/rcr_checker.sv
verif/rcr_checker.sv
verif/tb_top.sv
